@@ hdl/lew_pkg.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// lew_pkg: shared constants for the line editor with word wrap
// Holds line size, byte codes, register indexes and output sequence kinds.
// -----------------------------------------------------------------------------
package lew_pkg;

    localparam int LINE_CHARS = 40;
    localparam int LEN_W      = 7;
    localparam int IDX_W      = $clog2(LINE_CHARS);

    localparam logic [7:0] C_BEL = 8'd7;
    localparam logic [7:0] C_LF  = 8'd10;
    localparam logic [7:0] C_CR  = 8'd13;
    localparam logic [7:0] C_ESC = 8'd27;
    localparam logic [7:0] C_SP  = 8'h20;
    localparam logic [7:0] C_TIL = 8'h7E;
    localparam logic [7:0] C_LBR = 8'h5B;
    localparam logic [7:0] C_D   = 8'h44;
    localparam logic [7:0] C_K   = 8'h4B;
    localparam logic [7:0] C_2   = 8'h32;
    localparam logic [7:0] C_0   = 8'h30;

    localparam logic [1:0] REG_ERASE = 2'd0;
    localparam logic [1:0] REG_KILL  = 2'd1;
    localparam logic [1:0] REG_WERA  = 2'd2;
    localparam logic [1:0] REG_END   = 2'd3;

    // Sequences emitted by the output sequencer
    typedef enum logic [2:0] {
        SEQ_ONE,    // single byte
        SEQ_LEFT,   // ESC [ n D ESC [ K
        SEQ_KILL,   // ESC [ 2 K CR
        SEQ_MOVE,   // ESC [ w D ESC [ K LF then line
        SEQ_WRAP    // LF then byte
    } t_seq;

endpackage : lew_pkg
`default_nettype wire

@@ hdl/line_editor_with_word_wrap_unit.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// line_editor_with_word_wrap_unit: keyboard line editor with word wrap
// Keeps the current line in a RAM and emits the terminal bytes for each key.
// -----------------------------------------------------------------------------
// Order: a taken key is decoded in ST_DEC, a word erase or a wrap then scans in
//   ST_SCAN, and the output words are registered in ST_OUT (and ST_RD for a move).
// Flow: the line RAM is scanned one entry per read (up to 40 entries), escape words
//   go out one a cycle while the output is not stalled, and moved line words go out
//   as each is read back; the input is not ready until the whole key is done.
// Reset: synchronous active low; line empty, codes 127/21/23/4.
module line_editor_with_word_wrap_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] key_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic      [7:0] m_axis_tdata,   // [7:0] echo_byte
    output logic            m_axis_tlast,   // run_last
    output logic            m_axis_tuser,   // session_end
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [7:0] i_cfg_data
);
    import lew_pkg::*;

    typedef enum logic [2:0] {ST_IDLE, ST_DEC, ST_SCAN, ST_OUT, ST_RD} t_state;

    t_state           r_state;
    t_seq             r_seq;
    logic [7:0]       r_erase, r_kill, r_wera, r_end, r_key, r_byte;
    logic [LEN_W-1:0] r_len, r_i, r_cnt, r_wl, r_ws, r_k;
    logic [1:0]       r_phase;      // scan phase: 1 = spaces, 2 = word (word erase), 3 = word (wrap), 0 = done
    logic [3:0]       r_pos;
    logic             r_flag, r_end_out, r_busy;
    logic             r_mv_we;
    logic [IDX_W-1:0] r_mv_addr;
    logic [7:0]       r_mv_data;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]       ram_wdata, ram_rdata;
    logic [LEN_W-1:0] scan_idx;
    logic [LEN_W-1:0] mv_src;

    // Number digits for a count below 100
    logic [3:0] tens, ones;
    always_comb begin
        tens = 4'd0;
        for (int t = 1; t < 10; t++) begin
            if (r_cnt >= LEN_W'(t * 10)) tens = 4'(t);
        end
        ones = 4'(r_cnt - LEN_W'(tens) * LEN_W'(10));
    end

    // Line RAM
    lew_ram #(.WIDTH(8), .DEPTH(LINE_CHARS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign scan_idx      = r_i - LEN_W'(1);
    assign mv_src        = r_ws + r_k;
    assign ram_raddr     = (r_state == ST_OUT || r_state == ST_RD) ?
                           mv_src[IDX_W-1:0] : scan_idx[IDX_W-1:0];

    // Write port: store a key or move a word down
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_len[IDX_W-1:0];
        ram_wdata = r_key;
        if (r_state == ST_DEC && r_key >= C_SP && r_key <= C_TIL &&
            r_len < LEN_W'(LINE_CHARS)) begin
            ram_we = 1'b1;
        end else if (r_mv_we) begin
            ram_we    = 1'b1;
            ram_waddr = r_mv_addr;
            ram_wdata = r_mv_data;
        end
    end

    // Sequencer: decode, scan, emit
    always_ff @(posedge i_clk) begin
        r_mv_we <= 1'b0;
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_erase   <= 8'd127;
            r_kill    <= 8'd21;
            r_wera    <= 8'd23;
            r_end     <= 8'd4;
            r_len     <= '0;
            m_axis_tvalid <= 1'b0;
            r_mv_we   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_ERASE: r_erase <= i_cfg_data;
                    REG_KILL:  r_kill  <= i_cfg_data;
                    REG_WERA:  r_wera  <= i_cfg_data;
                    REG_END:   r_end   <= i_cfg_data;
                    default:   ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_key   <= s_axis_tdata;
                        r_state <= ST_DEC;
                    end
                end
                ST_DEC: begin
                    r_pos     <= '0;
                    r_end_out <= 1'b0;
                    r_seq     <= SEQ_ONE;
                    r_byte    <= C_BEL;
                    r_state   <= ST_OUT;
                    if (r_key < C_SP || r_key > C_TIL) begin
                        if (r_key == r_erase) begin
                            if (r_len != '0) begin
                                r_len <= r_len - LEN_W'(1);
                                r_cnt <= LEN_W'(1);
                                r_seq <= SEQ_LEFT;
                                r_flag <= 1'b0;
                            end
                        end else if (r_key == r_kill) begin
                            if (r_len != '0) begin
                                r_len <= '0;
                                r_seq <= SEQ_KILL;
                            end
                        end else if (r_key == r_wera) begin
                            if (r_len != '0) begin
                                r_i     <= r_len;
                                r_phase <= 2'd1;
                                r_busy  <= 1'b1;
                                r_state <= ST_SCAN;
                            end
                        end else if (r_key == r_end) begin
                            if (r_len == '0) begin
                                r_byte    <= C_LF;
                                r_end_out <= 1'b1;
                            end
                        end else if (r_key == C_CR || r_key == C_LF) begin
                            r_len  <= '0;
                            r_byte <= C_LF;
                        end
                    end else if (r_len < LEN_W'(LINE_CHARS)) begin
                        r_len  <= r_len + LEN_W'(1);
                        r_byte <= r_key;
                    end else if (r_key == C_SP) begin
                        r_len  <= '0;
                        r_byte <= C_LF;
                    end else begin
                        // Find start of last word, beginning before last char
                        r_i     <= r_len - LEN_W'(1);
                        r_phase <= 2'd3;
                        r_busy  <= 1'b1;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // r_busy: address presented, data next cycle
                    if (r_busy) begin
                        r_busy <= 1'b0;
                        if (r_i == '0) begin
                            r_busy  <= 1'b1;
                            r_state <= ST_SCAN;
                            r_phase <= 2'd0;
                        end
                    end else begin
                        r_busy <= 1'b1;
                        if (r_phase == 2'd1) begin
                            if (ram_rdata == C_SP) r_i <= r_i - LEN_W'(1);
                            else r_phase <= 2'd2;
                        end else if (r_phase == 2'd2 || r_phase == 2'd3) begin
                            if (ram_rdata != C_SP) r_i <= r_i - LEN_W'(1);
                            else r_phase <= 2'd0;
                        end
                    end
                    if (r_phase == 2'd0 || (r_busy && r_i == '0)) begin
                        r_pos   <= '0;
                        r_busy  <= 1'b0;
                        r_state <= ST_OUT;
                        if (r_key == r_wera && (r_key < C_SP || r_key > C_TIL)) begin
                            r_len <= r_i;
                            r_cnt <= r_len - r_i;
                            r_seq <= SEQ_LEFT;
                            r_flag <= 1'b1;
                        end else if (r_i == '0) begin
                            r_seq <= SEQ_WRAP;
                            r_len <= LEN_W'(1);
                            r_mv_we   <= 1'b1;
                            r_mv_addr <= '0;
                            r_mv_data <= r_key;
                        end else begin
                            r_seq  <= SEQ_MOVE;
                            r_ws   <= r_i;
                            r_wl   <= r_len - r_i;
                            r_cnt  <= r_len - r_i;
                            r_flag <= 1'b1;
                            r_k    <= '0;
                        end
                    end
                end
                ST_OUT: begin
                    // Emit one word per cycle when the output is free
                    if (!m_axis_tvalid || m_axis_tready) begin
                        m_axis_tvalid <= 1'b1;
                        m_axis_tuser  <= 1'b0;
                        m_axis_tlast  <= 1'b0;
                        r_pos <= r_pos + 4'd1;
                        unique case (r_seq)
                            SEQ_ONE: begin
                                m_axis_tdata <= r_byte;
                                m_axis_tuser <= r_end_out;
                                m_axis_tlast <= 1'b1;
                                r_state <= ST_IDLE;
                            end
                            SEQ_KILL: begin
                                case (r_pos)
                                    4'd0: m_axis_tdata <= C_ESC;
                                    4'd1: m_axis_tdata <= C_LBR;
                                    4'd2: m_axis_tdata <= C_2;
                                    4'd3: m_axis_tdata <= C_K;
                                    default: begin
                                        m_axis_tdata <= C_CR;
                                        m_axis_tlast <= 1'b1;
                                        r_state <= ST_IDLE;
                                    end
                                endcase
                            end
                            SEQ_WRAP: begin
                                if (r_pos == 4'd0) begin
                                    m_axis_tdata <= C_LF;
                                end else begin
                                    m_axis_tdata <= r_key;
                                    m_axis_tlast <= 1'b1;
                                    r_state <= ST_IDLE;
                                end
                            end
                            default: begin
                                // Left-clear with optional count; for a move, then LF and copy the word down
                                case (r_pos)
                                    4'd0, 4'd4: m_axis_tdata <= C_ESC;
                                    4'd1, 4'd5: m_axis_tdata <= C_LBR;
                                    4'd2: begin
                                        if (!r_flag) begin
                                            m_axis_tdata <= C_D;
                                            r_pos <= 4'd4;
                                        end else if (tens != 4'd0) begin
                                            m_axis_tdata <= C_0 + 8'(tens);
                                        end else begin
                                            m_axis_tdata <= C_0 + 8'(ones);
                                            r_pos <= 4'd8;
                                        end
                                    end
                                    4'd3: begin
                                        m_axis_tdata <= C_0 + 8'(ones);
                                        r_pos <= 4'd8;
                                    end
                                    4'd8: begin
                                        m_axis_tdata <= C_D;
                                        r_pos <= 4'd4;
                                    end
                                    4'd6: begin
                                        m_axis_tdata <= C_K;
                                        if (r_seq == SEQ_LEFT) begin
                                            m_axis_tlast <= 1'b1;
                                            r_state <= ST_IDLE;
                                        end
                                    end
                                    default: begin
                                        // LF, then copy word down and emit line
                                        m_axis_tdata <= C_LF;
                                        r_k   <= '0;
                                        r_state <= ST_RD;
                                        r_busy  <= 1'b0;
                                    end
                                endcase
                            end
                        endcase
                    end
                end
                ST_RD: begin
                    // r_k < r_wl: read ws+k, write at k, emit; then new char
                    if (!r_busy) begin
                        r_busy <= 1'b1;
                    end else if (!m_axis_tvalid || m_axis_tready) begin
                        r_busy <= 1'b0;
                        m_axis_tvalid <= 1'b1;
                        m_axis_tuser  <= 1'b0;
                        m_axis_tlast  <= 1'b0;
                        r_mv_we   <= 1'b1;
                        r_mv_addr <= r_k[IDX_W-1:0];
                        if (r_k == r_wl) begin
                            m_axis_tdata <= r_key;
                            m_axis_tlast <= 1'b1;
                            r_mv_data    <= r_key;
                            r_len        <= r_wl + LEN_W'(1);
                            r_state      <= ST_IDLE;
                        end else begin
                            m_axis_tdata <= ram_rdata;
                            r_mv_data    <= ram_rdata;
                            r_k          <= r_k + LEN_W'(1);
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (m_axis_tvalid && m_axis_tready &&
                !(r_state == ST_OUT) && !(r_state == ST_RD && r_busy)) begin
                m_axis_tvalid <= 1'b0;
            end
        end
    end
endmodule : line_editor_with_word_wrap_unit
`default_nettype wire

@@ hdl/lew_ram.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// lew_ram: generic single-port-write, one-read RAM
// Write at one address, registered read at another.
// -----------------------------------------------------------------------------
module lew_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 40
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule : lew_ram
`default_nettype wire

@@ hdl/lew_checker.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// lew_checker: port-level checks for the line editor
// Watches handshakes and run framing on the top-level ports.
// -----------------------------------------------------------------------------
module lew_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast,
    input wire logic       m_axis_tuser
);
    // Output word holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // Session end only on a final LF
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 8'd10)
        else $error("session end on wrong word");

    // No key taken right after another
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("key taken during work");
endmodule : lew_checker

bind line_editor_with_word_wrap_unit lew_checker u_lew_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
);
`default_nettype wire
